// ===== sv/gpzl_pkg.sv =====
// shared types, constants and corner tables of the geodesic zone locator
package gpzl_pkg;

  localparam int DEF_LEVELS     = 5;
  localparam int DEF_COORD_BITS = 16;
  localparam int NUM_FACES      = 20;
  localparam int ZONE_W         = 15;

  localparam logic CMD_LOCATE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  // corner component kinds: zero, +a, -a, +b, -b
  localparam int K_ZERO = 0;
  localparam int K_PA   = 1;
  localparam int K_NA   = 2;
  localparam int K_PB   = 3;
  localparam int K_NB   = 4;

  localparam int CORNER_KIND [12][3] = '{
    '{K_PA, K_NB, K_ZERO}, '{K_PA, K_PB, K_ZERO}, '{K_NA, K_PB, K_ZERO},
    '{K_NA, K_NB, K_ZERO}, '{K_ZERO, K_PA, K_NB}, '{K_ZERO, K_PA, K_PB},
    '{K_ZERO, K_NA, K_PB}, '{K_ZERO, K_NA, K_NB}, '{K_NB, K_ZERO, K_PA},
    '{K_PB, K_ZERO, K_PA}, '{K_PB, K_ZERO, K_NA}, '{K_NB, K_ZERO, K_NA}
  };

  localparam int FACE_CORNER [20][3] = '{
    '{1, 0, 10}, '{0, 1, 9}, '{0, 9, 6}, '{9, 8, 6}, '{0, 7, 10},
    '{6, 7, 0}, '{7, 6, 3}, '{6, 8, 3}, '{11, 10, 7}, '{7, 3, 11},
    '{3, 2, 11}, '{2, 3, 8}, '{10, 11, 4}, '{2, 4, 11}, '{5, 4, 2},
    '{2, 8, 5}, '{4, 1, 10}, '{4, 5, 1}, '{5, 9, 1}, '{8, 9, 5}
  };

  // control that travels with each word down the pipeline
  typedef struct packed {
    logic        valid;
    logic        cmd;
    logic        found;
    logic [3:0]  lvl;
    logic [2:0]  ent_lvl;
    logic [12:0] ent_idx;
    logic [1:0]  sel;
  } ctl_t;

  // corner magnitude rounded half-up from q1.31
  function automatic longint q_mag(input int cb, input bit is_a);
    longint raw;
    int     sh;
    raw = is_a ? 64'sd1826758701 : 64'sd1128998967;
    sh  = 32 - cb;
    return (raw + ((longint'(1) << sh) >> 1)) >>> sh;
  endfunction

  function automatic longint corner(input int cb, input int c, input int k);
    longint r;
    case (CORNER_KIND[c][k])
      K_PA:    r = q_mag(cb, 1'b1);
      K_NA:    r = -q_mag(cb, 1'b1);
      K_PB:    r = q_mag(cb, 1'b0);
      K_NB:    r = -q_mag(cb, 1'b0);
      default: r = 0;
    endcase
    return r;
  endfunction

  // component k of (ci x cj) for corner pair p of face f
  function automatic longint face_cross(input int cb, input int f, input int p, input int k);
    int ci, cj, k1, k2;
    ci = FACE_CORNER[f][p];
    cj = FACE_CORNER[f][(p == 2) ? 0 : p + 1];
    k1 = (k == 2) ? 0 : k + 1;
    k2 = (k == 0) ? 2 : k - 1;
    return corner(cb, ci, k1) * corner(cb, cj, k2) - corner(cb, ci, k2) * corner(cb, cj, k1);
  endfunction

endpackage

// ===== sv/gpzl_ram.sv =====
// generic simple dual port ram with registered read
module gpzl_ram #(
  parameter int W = 48,
  parameter int D = 20
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== sv/gpzl_face.sv =====
// top face search: constant triple products, then sign check and priority pick
module gpzl_face import gpzl_pkg::*; #(
  parameter int LEVELS     = DEF_LEVELS,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  ctl_t                      ctl_i,
  input  logic [3*COORD_BITS-1:0]   v_i,
  input  logic [3*COORD_BITS-1:0]   mid_i,
  output ctl_t                      ctl_o,
  output logic [3*COORD_BITS-1:0]   v_o,
  output logic [3*COORD_BITS-1:0]   mid_o,
  output logic [5+2*LEVELS-1:0]     zone_o
);
  localparam int CW = COORD_BITS;
  localparam int PW = 2*CW + 1;
  localparam int TW = 3*CW + 1;
  localparam int SW = TW + 2;
  localparam int ZW = 5 + 2*LEVELS;

  logic signed [TW-1:0] prod_r [NUM_FACES][3][3];
  logic signed [TW-1:0] prod_nxt [NUM_FACES][3][3];
  ctl_t                 ctl1_r, ctl2_r;
  ctl_t                 ctl2_nxt;
  logic [3*CW-1:0]      v1_r, mid1_r, v2_r, mid2_r;
  logic [ZW-1:0]        zone2_r, zone_nxt;
  logic                 found_nxt;
  logic                 hit [NUM_FACES];

  always_comb begin
    for (int f = 0; f < NUM_FACES; f++) begin
      for (int p = 0; p < 3; p++) begin
        for (int k = 0; k < 3; k++) begin
          prod_nxt[f][p][k] = TW'($signed(v_i[k*CW +: CW])) *
                              TW'($signed(PW'(face_cross(CW, f, p, k))));
        end
      end
    end
  end

  always_comb begin
    logic signed [SW-1:0] s;
    for (int f = 0; f < NUM_FACES; f++) begin
      hit[f] = 1'b1;
      for (int p = 0; p < 3; p++) begin
        s = SW'(prod_r[f][p][0]) + SW'(prod_r[f][p][1]) + SW'(prod_r[f][p][2]);
        if (s[SW-1]) begin
          hit[f] = 1'b0;
        end
      end
    end
    found_nxt = 1'b0;
    zone_nxt  = '0;
    for (int f = NUM_FACES - 1; f >= 0; f--) begin
      if (hit[f]) begin
        found_nxt = 1'b1;
        zone_nxt  = ZW'(f);
      end
    end
  end

  always_comb begin
    ctl2_nxt       = ctl1_r;
    ctl2_nxt.found = found_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r.valid <= 1'b0;
      ctl2_r.valid <= 1'b0;
    end else if (adv) begin
      ctl1_r <= ctl_i;
      ctl2_r <= ctl2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r  <= prod_nxt;
      v1_r    <= v_i;
      mid1_r  <= mid_i;
      v2_r    <= v1_r;
      mid2_r  <= mid1_r;
      zone2_r <= zone_nxt;
    end
  end

  assign ctl_o  = ctl2_r;
  assign v_o    = v2_r;
  assign mid_o  = mid2_r;
  assign zone_o = zone2_r;
endmodule

// ===== sv/gpzl_level.sv =====
// one subdivision level: midpoint ram read, cross products, dot terms, child pick
module gpzl_level import gpzl_pkg::*; #(
  parameter int LEVELS     = DEF_LEVELS,
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int LVL        = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  ctl_t                      ctl_i,
  input  logic [3*COORD_BITS-1:0]   v_i,
  input  logic [3*COORD_BITS-1:0]   mid_i,
  input  logic [5+2*LEVELS-1:0]     zone_i,
  output ctl_t                      ctl_o,
  output logic [3*COORD_BITS-1:0]   v_o,
  output logic [3*COORD_BITS-1:0]   mid_o,
  output logic [5+2*LEVELS-1:0]     zone_o
);
  localparam int CW    = COORD_BITS;
  localparam int PW    = 2*CW + 1;
  localparam int TW    = 3*CW + 1;
  localparam int SW    = TW + 2;
  localparam int ZW    = 5 + 2*LEVELS;
  localparam int DEPTH = 20 * (4 ** LVL);
  localparam int AW    = $clog2(DEPTH);

  ctl_t                 ctl_r  [4];
  logic [3*CW-1:0]      v_r    [4];
  logic [3*CW-1:0]      mid_r  [4];
  logic [ZW-1:0]        zone_r [4];
  logic [3*CW-1:0]      edge_q [3];
  logic signed [PW-1:0] cross_r [3][3];
  logic signed [PW-1:0] cross_nxt [3][3];
  logic signed [TW-1:0] term_r [3][3];
  logic signed [TW-1:0] term_nxt [3][3];
  logic [31:0]          idx_w;
  logic                 idx_ok;
  logic [1:0]           child;
  logic [ZW-1:0]        zone_nxt;

  assign idx_w  = {19'b0, ctl_i.ent_idx};
  assign idx_ok = idx_w < 32'(DEPTH);

  for (genvar s = 0; s < 3; s++) begin : g_ram
    gpzl_ram #(.W(3*CW), .D(DEPTH)) u_ram (
      .clk   (clk),
      .we    (adv && ctl_i.valid && ctl_i.cmd == CMD_LOAD && ctl_i.ent_lvl == 3'(LVL) &&
              ctl_i.sel == 2'(s) && idx_ok),
      .waddr (idx_w[AW-1:0]),
      .wdata (mid_i),
      .re    (adv),
      .raddr (zone_i[AW-1:0]),
      .rdata (edge_q[s])
    );
  end

  // pair 0 is e1 x e2, pair 1 is e2 x e0, pair 2 is e0 x e1
  always_comb begin
    logic signed [CW-1:0] a [3];
    logic signed [CW-1:0] b [3];
    for (int p = 0; p < 3; p++) begin
      for (int k = 0; k < 3; k++) begin
        a[k] = $signed(edge_q[(p == 2) ? 0 : p + 1][k*CW +: CW]);
        b[k] = $signed(edge_q[(p == 0) ? 2 : p - 1][k*CW +: CW]);
      end
      for (int k = 0; k < 3; k++) begin
        cross_nxt[p][k] = PW'(a[(k == 2) ? 0 : k + 1]) * PW'(b[(k == 0) ? 2 : k - 1]) -
                          PW'(a[(k == 0) ? 2 : k - 1]) * PW'(b[(k == 2) ? 0 : k + 1]);
      end
    end
  end

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      for (int k = 0; k < 3; k++) begin
        term_nxt[p][k] = TW'($signed(v_r[1][k*CW +: CW])) * TW'(cross_r[p][k]);
      end
    end
  end

  always_comb begin
    logic signed [SW-1:0] s [3];
    logic                 le [3];
    for (int p = 0; p < 3; p++) begin
      s[p]  = SW'(term_r[p][0]) + SW'(term_r[p][1]) + SW'(term_r[p][2]);
      le[p] = s[p][SW-1] || (s[p] == '0);
    end
    if (le[0]) begin
      child = 2'd0;
    end else if (le[1]) begin
      child = 2'd1;
    end else if (le[2]) begin
      child = 2'd2;
    end else begin
      child = 2'd3;
    end
    if (ctl_r[2].found && ctl_r[2].lvl > 4'(LVL)) begin
      zone_nxt = {zone_r[2][ZW-3:0], child};
    end else begin
      zone_nxt = zone_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) begin
        ctl_r[k].valid <= 1'b0;
      end
    end else if (adv) begin
      ctl_r[0] <= ctl_i;
      for (int k = 1; k < 4; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v_r[0]    <= v_i;
      mid_r[0]  <= mid_i;
      zone_r[0] <= zone_i;
      for (int k = 1; k < 4; k++) begin
        v_r[k]   <= v_r[k-1];
        mid_r[k] <= mid_r[k-1];
      end
      zone_r[1] <= zone_r[0];
      zone_r[2] <= zone_r[1];
      zone_r[3] <= zone_nxt;
      cross_r   <= cross_nxt;
      term_r    <= term_nxt;
    end
  end

  assign ctl_o  = ctl_r[3];
  assign v_o    = v_r[3];
  assign mid_o  = mid_r[3];
  assign zone_o = zone_r[3];
endmodule

// ===== sv/geodesic_point_zone_locate.sv =====
// top level of the geodesic zone locator: input decode, face search, level chain, output
//
//   channel | ports   | direction | moves
//   --------+---------+-----------+--------------------------------------------
//   input   | in_*    | slave     | locate or midpoint-load word
//   result  | out_*   | master    | zone word, one per locate, none per load
//
// one word enters per cycle while no result is held; each word passes through
// the two face-search stages and the four stages of each level
// a load writes its midpoint when it passes its level's ram stage, so it takes effect
// in order with the locates around it
// rst_n is synchronous, active low, and clears the valid bits only
// a held result freezes every stage at once; in_tready is low for that cycle
module geodesic_point_zone_locate import gpzl_pkg::*; #(
  parameter int LEVELS     = DEF_LEVELS,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // point_x, point_y, point_z, search_level, entry_level, entry_index,
  // midpoint_select, mid_x, mid_y, mid_z, zero fill
  input  logic [((6*COORD_BITS+21+7)/8)*8-1:0]   in_tdata,
  // command
  input  logic                                   in_tuser,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // zone_index, zero fill
  output logic [15:0]                            out_tdata,
  // not_found
  output logic                                   out_tuser
);
  localparam int CW   = COORD_BITS;
  localparam int ZW   = 5 + 2*LEVELS;
  localparam int OFS  = 3*CW;

  ctl_t            in_ctl;
  logic            adv;
  logic [3:0]      lvl_raw;
  ctl_t            lv_ctl  [LEVELS+1];
  logic [3*CW-1:0] lv_v    [LEVELS+1];
  logic [3*CW-1:0] lv_mid  [LEVELS+1];
  logic [ZW-1:0]   lv_zone [LEVELS+1];
  logic [ZW+ZONE_W-1:0] zone_ext;

  // the whole pipeline moves unless a finished result is held
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // deep searches saturate at the stored depth
  assign lvl_raw = {1'b0, in_tdata[OFS+2:OFS]};
  always_comb begin
    in_ctl.valid   = in_tvalid;
    in_ctl.cmd     = in_tuser;
    in_ctl.found   = 1'b0;
    in_ctl.lvl     = (lvl_raw > 4'(LEVELS)) ? 4'(LEVELS) : lvl_raw;
    in_ctl.ent_lvl = in_tdata[OFS+5:OFS+3];
    in_ctl.ent_idx = in_tdata[OFS+18:OFS+6];
    in_ctl.sel     = in_tdata[OFS+20:OFS+19];
  end

  gpzl_face #(.LEVELS(LEVELS), .COORD_BITS(COORD_BITS)) u_face (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .ctl_i  (in_ctl),
    .v_i    (in_tdata[3*CW-1:0]),
    .mid_i  (in_tdata[6*CW+20:3*CW+21]),
    .ctl_o  (lv_ctl[0]),
    .v_o    (lv_v[0]),
    .mid_o  (lv_mid[0]),
    .zone_o (lv_zone[0])
  );

  // one level unit per subdivision step
  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    gpzl_level #(.LEVELS(LEVELS), .COORD_BITS(COORD_BITS), .LVL(l)) u_level (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .ctl_i  (lv_ctl[l]),
      .v_i    (lv_v[l]),
      .mid_i  (lv_mid[l]),
      .zone_i (lv_zone[l]),
      .ctl_o  (lv_ctl[l+1]),
      .v_o    (lv_v[l+1]),
      .mid_o  (lv_mid[l+1]),
      .zone_o (lv_zone[l+1])
    );
  end

  // last level register is the output register; load words just drop out
  assign out_tvalid = lv_ctl[LEVELS].valid && lv_ctl[LEVELS].cmd == CMD_LOCATE;
  assign zone_ext   = lv_ctl[LEVELS].found ? {{ZONE_W{1'b0}}, lv_zone[LEVELS]} : '0;
  assign out_tdata  = {1'b0, zone_ext[ZONE_W-1:0]};
  assign out_tuser  = !lv_ctl[LEVELS].found;
endmodule

// ===== sv/gpzl_chk.sv =====
// port-level checker for the geodesic zone locator, bound to the top level
module gpzl_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser
);
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid right after reset");

  a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 16'd0)
    else $error("not_found word carries a nonzero zone");

  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while result word is held");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");
endmodule

bind geodesic_point_zone_locate gpzl_chk u_chk (.*);

// ===== bench/tb_geodesic_point_zone_locate.sv =====
// testbench of the geodesic zone locator: random locate and midpoint-load words, scoreboard
module tb_geodesic_point_zone_locate;
  import gpzl_pkg::*;

  localparam int NLVL      = 5;
  localparam int TAB_DEPTH = 20460;
  localparam int DW        = 120;
  localparam int LATENCY   = 2 + 4 * NLVL;
  localparam int CYC_LIMIT = 400000;
  localparam longint QA    = 27874;
  localparam longint QB    = 17227;

  // corner vectors of the icosahedron, q1.15
  localparam longint CORNER_VEC [12][3] = '{
    '{QA, -QB, 0}, '{QA, QB, 0}, '{-QA, QB, 0}, '{-QA, -QB, 0},
    '{0, QA, -QB}, '{0, QA, QB}, '{0, -QA, QB}, '{0, -QA, -QB},
    '{-QB, 0, QA}, '{QB, 0, QA}, '{QB, 0, -QA}, '{-QB, 0, -QA}
  };
  localparam int FACE_CORNERS [20][3] = '{
    '{1, 0, 10}, '{0, 1, 9}, '{0, 9, 6}, '{9, 8, 6}, '{0, 7, 10},
    '{6, 7, 0}, '{7, 6, 3}, '{6, 8, 3}, '{11, 10, 7}, '{7, 3, 11},
    '{3, 2, 11}, '{2, 3, 8}, '{10, 11, 4}, '{2, 4, 11}, '{5, 4, 2},
    '{2, 8, 5}, '{4, 1, 10}, '{4, 5, 1}, '{5, 9, 1}, '{8, 9, 5}
  };

  typedef struct {
    logic               cmd;
    logic signed [15:0] px, py, pz;
    logic [2:0]         slvl, elvl;
    logic [12:0]        eidx;
    logic [1:0]         sel;
    logic signed [15:0] mx, my, mz;
    logic [14:0]        zone;      // expected zone for a locate
    logic               miss;      // expected not_found
  } word_t;

  typedef struct {
    logic [14:0] zone;
    logic        miss;
  } zone_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [DW-1:0] in_tdata = '0;
  logic          in_tuser = 1'b0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [15:0]   out_tdata;
  logic          out_tuser;

  // shadow of the midpoint table, kept in word order
  longint mid_tab [TAB_DEPTH][3];
  bit     mid_set [TAB_DEPTH];

  word_t  pending_words[$];
  zone_t  zones_due[$];
  word_t  cur_word;
  bit     took_word = 1'b0;
  int     send_gap = 0;
  int     recv_gap = 0;
  int     hold_left = 0;
  bit     hold_done = 1'b0;
  int     cycle_cnt = 0;
  int     fail_cnt = 0;
  bit     no_idle = 1'b0;

  geodesic_point_zone_locate dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #2 clk = ~clk;

  // sign of (a x b) . v, exact at 16-bit components
  function automatic int triple_sign(input longint a[3], input longint b[3], input longint v[3]);
    longint s;
    s = v[0] * (a[1] * b[2] - a[2] * b[1]) + v[1] * (a[2] * b[0] - a[0] * b[2])
      + v[2] * (a[0] * b[1] - a[1] * b[0]);
    return (s < 0) ? -1 : (s == 0 ? 0 : 1);
  endfunction

  // first table entry of a level
  function automatic int level_base(input int lv);
    int b, c;
    b = 0;
    c = 20;
    for (int l = 0; l < lv; l++) begin
      b += c;
      c *= 4;
    end
    return b;
  endfunction

  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // a load word; valid addresses update the shadow table as the word is queued
  task automatic queue_load(input int lv, input int idx, input int s,
                            input longint x, input longint y, input longint z);
    word_t w;
    int    e;
    w = '{default: '0};
    w.cmd  = CMD_LOAD;
    w.elvl = lv[2:0];
    w.eidx = idx[12:0];
    w.sel  = s[1:0];
    w.mx   = x[15:0];
    w.my   = y[15:0];
    w.mz   = z[15:0];
    w.px   = 16'($urandom());
    w.py   = 16'($urandom());
    w.pz   = 16'($urandom());
    w.slvl = 3'($urandom());
    if (lv < NLVL && s < 3 && idx < 20 * (1 << (2 * lv))) begin
      e = (level_base(lv) + idx) * 3 + s;
      mid_tab[e] = '{longint'(w.mx), longint'(w.my), longint'(w.mz)};
      mid_set[e] = 1'b1;
    end
    pending_words.push_back(w);
  endtask

  function automatic longint rand_comp();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return -32768;
    if (r == 1) return 32767;
    if (r < 5) return $signed(16'($urandom_range(0, 65535))) >>> $urandom_range(0, 4);
    return longint'($signed(16'($urandom())));
  endfunction

  // locate word: loads any midpoint its path needs first, then predicts the zone
  task automatic queue_locate(input longint x, input longint y, input longint z,
                              input int lv_req);
    word_t  w;
    longint v[3], c0[3], c1[3], c2[3], e0[3], e1[3], e2[3];
    int     lv, zone, ent, idx;
    bit     hit;
    w = '{default: '0};
    w.cmd  = CMD_LOCATE;
    w.px   = x[15:0];
    w.py   = y[15:0];
    w.pz   = z[15:0];
    w.slvl = lv_req[2:0];
    w.elvl = 3'($urandom());
    w.eidx = 13'($urandom());
    w.sel  = 2'($urandom());
    w.mx   = 16'($urandom());
    w.my   = 16'($urandom());
    w.mz   = 16'($urandom());
    v  = '{longint'(w.px), longint'(w.py), longint'(w.pz)};
    lv = (lv_req > NLVL) ? NLVL : lv_req;
    hit = 1'b0;
    zone = 0;
    for (int f = 0; f < 20 && !hit; f++) begin
      c0 = CORNER_VEC[FACE_CORNERS[f][0]];
      c1 = CORNER_VEC[FACE_CORNERS[f][1]];
      c2 = CORNER_VEC[FACE_CORNERS[f][2]];
      if (triple_sign(c0, c1, v) >= 0 && triple_sign(c1, c2, v) >= 0 &&
          triple_sign(c2, c0, v) >= 0) begin
        hit = 1'b1;
        zone = f;
      end
    end
    if (hit) begin
      for (int l = 0; l < lv; l++) begin
        idx = zone;
        ent = (level_base(l) + idx) * 3;
        // never let the block read a midpoint that was not written
        for (int s = 0; s < 3; s++)
          if (!mid_set[ent + s])
            queue_load(l, idx, s, rand_comp(), rand_comp(), rand_comp());
        e0 = mid_tab[ent];
        e1 = mid_tab[ent + 1];
        e2 = mid_tab[ent + 2];
        zone = zone * 4;
        if (triple_sign(e1, e2, v) <= 0) zone += 0;
        else if (triple_sign(e2, e0, v) <= 0) zone += 1;
        else if (triple_sign(e0, e1, v) <= 0) zone += 2;
        else zone += 3;
      end
    end
    w.zone = hit ? zone[14:0] : '0;
    w.miss = !hit;
    pending_words.push_back(w);
  endtask

  function automatic logic [DW-1:0] pack_word(input word_t w);
    logic [DW-1:0] d;
    d = '0;
    d[15:0]    = w.px;
    d[31:16]   = w.py;
    d[47:32]   = w.pz;
    d[50:48]   = w.slvl;
    d[53:51]   = w.elvl;
    d[66:54]   = w.eidx;
    d[68:67]   = w.sel;
    d[84:69]   = w.mx;
    d[100:85]  = w.my;
    d[116:101] = w.mz;
    return d;
  endfunction

  // input driver: holds a word until taken, then waits its gap
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || took_word)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        cur_word <= pending_words[0];
        in_tdata <= pack_word(pending_words[0]);
        in_tuser <= pending_words[0].cmd;
        void'(pending_words.pop_front());
        in_tvalid <= 1'b1;
        send_gap <= random_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // input acceptance: a locate word leaves one zone expectation
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    took_word <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready && cur_word.cmd == CMD_LOCATE)
      zones_due.push_back('{zone: cur_word.zone, miss: cur_word.miss});
  end

  // receiver: random stalls, one long hold-off so the pipe fills and stalls the input
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && cycle_cnt > 600) begin
      hold_done <= 1'b1;
      hold_left <= 150;
      out_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!no_idle && $urandom_range(0, 3) == 0) recv_gap <= random_gap();
    end
  end

  // idle-free stretches come and go
  always @(negedge clk)
    if (cycle_cnt % 500 == 0) no_idle <= ($urandom_range(0, 3) == 0);

  // result monitor
  always @(posedge clk) begin
    zone_t z;
    if (rst_n && out_tvalid && out_tready) begin
      if (zones_due.size() == 0) begin
        $error("zone word with no locate waiting: zone_index %0d", out_tdata[14:0]);
        fail_cnt <= fail_cnt + 1;
      end else begin
        z = zones_due.pop_front();
        if (out_tdata[14:0] !== z.zone) begin
          $error("zone_index expected %0d actual %0d", z.zone, out_tdata[14:0]);
          fail_cnt <= fail_cnt + 1;
        end
        if (out_tdata[15] !== 1'b0) begin
          $error("zero fill expected 0 actual %b", out_tdata[15]);
          fail_cnt <= fail_cnt + 1;
        end
        if (out_tuser !== z.miss) begin
          $error("not_found expected %0d actual %0d", z.miss, out_tuser);
          fail_cnt <= fail_cnt + 1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk)
    if (cycle_cnt >= CYC_LIMIT) begin
      $display("simulation failed");
      $finish;
    end

  initial begin
    int r, c, f;
    // directed: bad load addresses are dropped by the block
    queue_load(5, 0, 0, 1, 2, 3);
    queue_load(7, 3, 1, -32768, 32767, 0);
    queue_load(0, 20, 0, 5, 5, 5);
    queue_load(4, 8191, 2, 7, 7, 7);
    queue_load(2, 1, 3, 9, 9, 9);
    // extreme valid addresses and values
    queue_load(4, 5119, 2, -32768, -32768, -32768);
    queue_load(4, 5119, 0, 32767, 32767, 32767);
    queue_load(0, 0, 0, 0, 0, 0);
    // zero vector sits on every boundary: first face and first child win
    queue_locate(0, 0, 0, 5);
    queue_locate(32767, 32767, 32767, 0);
    queue_locate(-32768, -32768, -32768, 3);
    queue_locate(-32768, 32767, -32768, 7);
    queue_locate(32767, -32768, 0, 6);
    // corners and an edge point between two faces
    queue_locate(QA, -QB, 0, 5);
    queue_locate(0, -QA, QB, 2);
    queue_locate(QA, 0, 0, 1);
    queue_locate(-QB, 0, -QA, 4);
    // random part: mostly locates that descend, some loads and bad loads as noise
    while (pending_words.size() < 1250) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        if ($urandom_range(0, 3) == 0) begin
          // near a corner, its z part sometimes zeroed, so boundaries get exercised
          c = $urandom_range(0, 11);
          f = $urandom_range(0, 20);
          queue_locate(CORNER_VEC[c][0] + $urandom_range(0, 6) - 3,
                       CORNER_VEC[c][1] + $urandom_range(0, 6) - 3,
                       CORNER_VEC[c][2] * (f % 2) + $urandom_range(0, 2) - 1,
                       $urandom_range(0, 7));
        end else begin
          queue_locate(rand_comp(), rand_comp(), rand_comp(),
                       ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : NLVL);
        end
      end else if (r < 88) begin
        c = $urandom_range(0, NLVL - 1);
        queue_load(c, $urandom_range(0, 20 * (1 << (2 * c)) - 1), $urandom_range(0, 2),
                   rand_comp(), rand_comp(), rand_comp());
      end else begin
        queue_load($urandom_range(0, 7), $urandom_range(0, 8191), $urandom_range(0, 3),
                   rand_comp(), rand_comp(), rand_comp());
      end
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    wait (pending_words.size() == 0 && !in_tvalid && zones_due.size() == 0);
    repeat (LATENCY * 4) @(posedge clk);
    if (fail_cnt == 0 && zones_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/gpzl_pkg.sv
sv/gpzl_ram.sv
sv/gpzl_face.sv
sv/gpzl_level.sv
sv/geodesic_point_zone_locate.sv
sv/gpzl_chk.sv
bench/tb_geodesic_point_zone_locate.sv
